// ===== design/rtcbcd_pkg.sv =====
// Package for the calendar time to BCD register encoder: field widths,
// bus packing offsets, the result struct and small calendar/BCD helpers.
// No dependencies.
package rtcbcd_pkg;

  // Input field widths
  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 12;

  // Output field widths
  localparam int unsigned SecBcdW  = 7;
  localparam int unsigned MinBcdW  = 7;
  localparam int unsigned HourByteW = 8;
  localparam int unsigned WdayOutW = 3;
  localparam int unsigned DayBcdW  = 6;
  localparam int unsigned MonBcdW  = 5;
  localparam int unsigned YearBcdW = 8;

  localparam int unsigned InBits  = SecW + MinW + HourW + WdayW + DayW + MonW + YearW;
  localparam int unsigned OutBits = SecBcdW + MinBcdW + HourByteW + WdayOutW + DayBcdW
                                    + MonBcdW + YearBcdW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // Bit offsets inside s_tdata
  localparam int unsigned SecLo  = 0;
  localparam int unsigned MinLo  = SecLo + SecW;
  localparam int unsigned HourLo = MinLo + MinW;
  localparam int unsigned WdayLo = HourLo + HourW;
  localparam int unsigned DayLo  = WdayLo + WdayW;
  localparam int unsigned MonLo  = DayLo + DayW;
  localparam int unsigned YearLo = MonLo + MonW;

  // Bit offsets inside m_tdata
  localparam int unsigned OSecLo  = 0;
  localparam int unsigned OMinLo  = OSecLo + SecBcdW;
  localparam int unsigned OHourLo = OMinLo + MinBcdW;
  localparam int unsigned OWdayLo = OHourLo + HourByteW;
  localparam int unsigned ODayLo  = OWdayLo + WdayOutW;
  localparam int unsigned OMonLo  = ODayLo + DayBcdW;
  localparam int unsigned OYearLo = OMonLo + MonBcdW;

  // Calendar limits
  localparam logic [YearW-1:0] YearFirst = 12'd2000;
  localparam logic [YearW-1:0] YearLast  = 12'd2099;
  localparam logic [HourW-1:0] HourMax   = 5'd23;
  localparam logic [SecW-1:0]  MinSecMax = 6'd59;
  localparam logic [WdayW-1:0] WdayMax   = 3'd6;
  localparam logic [HourByteW-1:0] Flag24h = 8'h80;

  // Status codes
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

  typedef struct packed {
    logic                  status;
    logic [SecBcdW-1:0]    second_bcd;
    logic [MinBcdW-1:0]    minute_bcd;
    logic [HourByteW-1:0]  hour_byte;
    logic [WdayOutW-1:0]   weekday_byte;
    logic [DayBcdW-1:0]    day_bcd;
    logic [MonBcdW-1:0]    month_bcd;
    logic [YearBcdW-1:0]   year_bcd;
  } rtcbcd_res_t;

  // Days in a month; zero for a month number outside 1..12
  function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // Two BCD digits of a value below 100: tens by reciprocal multiply
  function automatic logic [7:0] to_bcd2(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

// ===== design/rtcbcd_encode.sv =====
// Range check and BCD packing of one calendar time, purely combinational.
// Depends on rtcbcd_pkg.
module rtcbcd_encode (
  input  logic [rtcbcd_pkg::InDataW-1:0] time_word,
  output rtcbcd_pkg::rtcbcd_res_t        res
);
  import rtcbcd_pkg::*;

  logic [SecW-1:0]  sec;
  logic [MinW-1:0]  min;
  logic [HourW-1:0] hr;
  logic [WdayW-1:0] wd;
  logic [DayW-1:0]  dy;
  logic [MonW-1:0]  mo;
  logic [YearW-1:0] yr;
  logic [YearW-1:0] yr_off;
  logic             leap;
  logic [DayW-1:0]  mdays;
  logic             ok;

  assign sec = time_word[SecLo  +: SecW];
  assign min = time_word[MinLo  +: MinW];
  assign hr  = time_word[HourLo +: HourW];
  assign wd  = time_word[WdayLo +: WdayW];
  assign dy  = time_word[DayLo  +: DayW];
  assign mo  = time_word[MonLo  +: MonW];
  assign yr  = time_word[YearLo +: YearW];

  // Within 2000..2099 the year mod 100 is the offset from 2000, and the
  // leap rule reduces to divisibility by 4 (2000 is a 400-year)
  assign yr_off = yr - YearFirst;
  assign leap   = (yr[1:0] == 2'b00);
  assign mdays  = month_days(mo, leap);

  assign ok = (yr >= YearFirst) && (yr <= YearLast)
           && (dy != '0) && (dy <= mdays)
           && (wd <= WdayMax) && (hr <= HourMax)
           && (min <= MinSecMax) && (sec <= MinSecMax);

  always_comb begin
    res = '0;
    if (ok) begin
      res.status       = StatusOk;
      res.second_bcd   = SecBcdW'(to_bcd2(7'(sec)));
      res.minute_bcd   = MinBcdW'(to_bcd2(7'(min)));
      res.hour_byte    = Flag24h | to_bcd2(7'(hr));
      res.weekday_byte = wd;
      res.day_bcd      = DayBcdW'(to_bcd2(7'(dy)));
      res.month_bcd    = MonBcdW'(to_bcd2(7'(mo)));
      res.year_bcd     = to_bcd2(yr_off[6:0]);
    end else begin
      res.status = StatusInvalid;
    end
  end

endmodule

// ===== design/rtc_time_bcd_encoder.sv =====
// Top level of the calendar time to BCD register encoder: input register,
// check/pack logic, result register with stream handshakes.
// Depends on rtcbcd_pkg and rtcbcd_encode.
//
//  channel | dir | payload (low bit first)                                 | tuser
//  s_*     | in  | second, minute, hour, weekday, day, month, year (41 b)    | -
//  m_*     | out | second_bcd, minute_bcd, hour_byte, weekday_byte, day_bcd, | status
//          |     | month_bcd, year_bcd (44 b)                               |
//
// One item per cycle while m_tready is high; an accepted item is captured in
// the input register, then the check logic result is captured in the result
// register, which drives m_tvalid, m_tdata and m_tuser.
// rst clears both valid flags; payload registers are not reset.
// A stalled result holds in the result register while an item waits in the
// input register; s_tready drops only when both stages are full and m_tready
// is low.
module rtc_time_bcd_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rtcbcd_pkg::InDataW-1:0]  s_tdata,   // second, minute, hour, weekday,
                                                     // day, month, year; zero fill
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rtcbcd_pkg::OutDataW-1:0] m_tdata,   // second_bcd, minute_bcd, hour_byte,
                                                     // weekday_byte, day_bcd, month_bcd,
                                                     // year_bcd; zero fill
  output logic                            m_tuser    // status: 0 ok, 1 invalid
);
  import rtcbcd_pkg::*;

  logic               in_valid;
  logic [InDataW-1:0] in_data;
  logic               out_valid;
  rtcbcd_res_t        out_res;
  rtcbcd_res_t        enc_res;
  logic               out_load;

  // Result stage takes a new item whenever it is empty or being drained
  assign out_load = !out_valid || m_tready;
  assign s_tready = !in_valid || out_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
  end

  rtcbcd_encode u_encode (
    .time_word (in_data),
    .res       (enc_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
    if (out_load && in_valid) begin
      out_res <= enc_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = OutDataW'({out_res.year_bcd, out_res.month_bcd, out_res.day_bcd,
                               out_res.weekday_byte, out_res.hour_byte,
                               out_res.minute_bcd, out_res.second_bcd});

endmodule

// ===== design/rtcbcd_checker.sv =====
// Port-level checks for the calendar time to BCD register encoder, bound to
// the top level. Depends on rtcbcd_pkg and rtc_time_bcd_encoder.
module rtcbcd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rtcbcd_pkg::OutDataW-1:0] m_tdata,
  input logic                            m_tuser
);
  import rtcbcd_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // No result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Invalid time carries all-zero bytes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == StatusInvalid) |-> m_tdata == '0)
    else $error("invalid time with nonzero bytes");

  // Valid time: 24-hour flag set and weekday in range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == StatusOk) |->
      m_tdata[OHourLo + HourByteW - 1] && (m_tdata[OWdayLo +: WdayOutW] <= WdayMax))
    else $error("valid time with bad hour flag or weekday");

  // An accepted item reaches the output while m_tready stays high after acceptance
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 m_tready ##1 m_tready |-> m_tvalid || $past(m_tvalid))
    else $error("accepted item lost");

endmodule

bind rtc_time_bcd_encoder rtcbcd_checker u_rtcbcd_checker (.*);
